// ===== sv/wfgd_pkg.sv =====
// ----------------------------------------------------------------------------
// wfgd_pkg
// Shared types, codes and defaults for the wait-for graph deadlock detector.
// ----------------------------------------------------------------------------
`default_nettype none

package wfgd_pkg;

   localparam int MAX_PROCS_DEF = 16;
   localparam int KEY_BITS_DEF  = 16;

   localparam int ACTION_W = 3;
   localparam int KEY_W    = 16;
   localparam int SLOTS_W  = 5;

   localparam logic [ACTION_W-1:0] ACT_ADD_WAIT    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE_WAIT = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR_WAITS = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_REMOVE_PROC = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CLEAR_ALL   = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_DETECT      = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_QUERY       = 3'd6;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [KEY_W-1:0]    waiting_key;
      logic [KEY_W-1:0]    holding_key;
   } req_type;

   typedef struct packed {
      logic               deadlock;
      logic               table_full;
      logic [SLOTS_W-1:0] slots_used;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK_W,
      ST_RES_W,
      ST_LOOK_H,
      ST_RES_H,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_req;
      logic look_w;
      logic look_h;
      logic alloc_w;
      logic alloc_h;
      logic set_full;
      logic set_edge;
      logic clr_edge;
      logic clr_row;
      logic clr_col;
      logic clr_all;
      logic scan_init;
      logic scan_step;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                w_hit;
      logic                h_hit;
      logic                count_full;
      logic                scan_stable;
   } dp_sts_type;

endpackage

`default_nettype wire

// ===== sv/wfgd_dp.sv =====
// ----------------------------------------------------------------------------
// wfgd_dp
// Datapath: key table, wait matrix, slot lookup and reachability scan.
// ----------------------------------------------------------------------------
`default_nettype none

module wfgd_dp #(
   parameter int MAX_PROCS = wfgd_pkg::MAX_PROCS_DEF,
   parameter int KEY_BITS  = wfgd_pkg::KEY_BITS_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire wfgd_pkg::req_type    req_payload,
   input  wire wfgd_pkg::dp_cmd_type cmd,
   output wfgd_pkg::dp_sts_type   sts,
   output wfgd_pkg::rsp_type      rsp_payload
);
   import wfgd_pkg::*;

   localparam int SLOT_W = $clog2(MAX_PROCS);
   localparam int CNT_W  = $clog2(MAX_PROCS + 1);
   localparam int MASK_W = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

   req_type                 req_ff, req_in;
   logic [KEY_BITS-1:0]     key_ff [MAX_PROCS];
   logic [KEY_BITS-1:0]     key_in [MAX_PROCS];
   logic [MAX_PROCS-1:0]    row_ff [MAX_PROCS];
   logic [MAX_PROCS-1:0]    row_in [MAX_PROCS];
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [SLOT_W-1:0]       w_slot_ff, w_slot_in;
   logic [SLOT_W-1:0]       h_slot_ff, h_slot_in;
   logic                    w_hit_ff, w_hit_in;
   logic                    h_hit_ff, h_hit_in;
   logic                    full_ff, full_in;
   logic [MAX_PROCS-1:0]    scan_ff, scan_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [KEY_BITS-1:0]     wkey, hkey, look_key;
   logic [MAX_PROCS-1:0]    match;
   logic                    look_hit;
   logic [SLOT_W-1:0]       look_slot;
   logic                    count_full;
   logic [SLOT_W-1:0]       alloc_slot;
   logic [MAX_PROCS-1:0]    count_mask;
   logic [MAX_PROCS-1:0]    reach_or, peel, scan_next, scan_init;
   logic                    detect_mode;
   logic                    deadlock;

   // key masking and lookup
   always_comb begin
      wkey       = KEY_BITS'(req_ff.waiting_key[MASK_W-1:0]);
      hkey       = KEY_BITS'(req_ff.holding_key[MASK_W-1:0]);
      look_key   = cmd.look_h ? hkey : wkey;
      look_slot  = '0;
      count_mask = '0;
      for (int i = 0; i < MAX_PROCS; i++) begin
         count_mask[i] = CNT_W'(i) < count_ff;
         match[i]      = count_mask[i] && (key_ff[i] == look_key);
         if (match[i]) begin
            look_slot = look_slot | SLOT_W'(i);
         end
      end
      look_hit   = |match;
      count_full = count_ff == CNT_W'(MAX_PROCS);
      alloc_slot = count_ff[SLOT_W-1:0];
   end

   // one reachability pass: query grows the reach set, detect peels sinks
   always_comb begin
      detect_mode = req_ff.action == ACT_DETECT;
      reach_or    = '0;
      for (int i = 0; i < MAX_PROCS; i++) begin
         if (scan_ff[i]) begin
            reach_or = reach_or | row_ff[i];
         end
         peel[i] = scan_ff[i] && |(row_ff[i] & scan_ff);
      end
      scan_next = detect_mode ? peel : (scan_ff | reach_or);
      scan_init = detect_mode ? count_mask : row_ff[w_slot_ff];
   end

   always_comb begin
      case (req_ff.action)
         ACT_DETECT: deadlock = |scan_ff;
         ACT_QUERY:  deadlock = w_hit_ff && scan_ff[w_slot_ff];
         default:    deadlock = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      req_in    = cmd.load_req ? req_payload : req_ff;
      key_in    = key_ff;
      row_in    = row_ff;
      count_in  = count_ff;
      w_slot_in = w_slot_ff;
      h_slot_in = h_slot_ff;
      w_hit_in  = w_hit_ff;
      h_hit_in  = h_hit_ff;
      full_in   = full_ff;
      scan_in   = scan_ff;
      rsp_in    = rsp_ff;

      if (cmd.load_req) begin
         w_hit_in = 1'b0;
         h_hit_in = 1'b0;
         full_in  = 1'b0;
      end
      if (cmd.look_w) begin
         w_hit_in  = look_hit;
         w_slot_in = look_slot;
      end
      if (cmd.look_h) begin
         h_hit_in  = look_hit;
         h_slot_in = look_slot;
      end
      if (cmd.alloc_w || cmd.alloc_h) begin
         key_in[alloc_slot] = cmd.alloc_w ? wkey : hkey;
         row_in[alloc_slot] = '0;
         count_in           = count_ff + CNT_W'(1);
      end
      if (cmd.alloc_w) begin
         w_hit_in  = 1'b1;
         w_slot_in = alloc_slot;
      end
      if (cmd.alloc_h) begin
         h_hit_in  = 1'b1;
         h_slot_in = alloc_slot;
      end
      if (cmd.set_full) begin
         full_in = 1'b1;
      end
      if (cmd.set_edge) begin
         row_in[w_slot_ff][h_slot_ff] = 1'b1;
      end
      if (cmd.clr_edge) begin
         row_in[w_slot_ff][h_slot_ff] = 1'b0;
      end
      if (cmd.clr_row) begin
         row_in[w_slot_ff] = '0;
      end
      if (cmd.clr_col) begin
         for (int i = 0; i < MAX_PROCS; i++) begin
            row_in[i][w_slot_ff] = 1'b0;
         end
      end
      if (cmd.clr_all) begin
         for (int i = 0; i < MAX_PROCS; i++) begin
            row_in[i] = '0;
         end
         count_in = '0;
         w_hit_in = 1'b0;
         h_hit_in = 1'b0;
      end
      if (cmd.scan_init) begin
         scan_in = scan_init;
      end else if (cmd.scan_step) begin
         scan_in = scan_next;
      end
      if (cmd.load_rsp) begin
         rsp_in.deadlock   = deadlock;
         rsp_in.table_full = full_ff;
         rsp_in.slots_used = SLOTS_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PROCS; i++) begin
            row_ff[i] <= '0;
         end
         count_ff <= '0;
         w_hit_ff <= 1'b0;
         h_hit_ff <= 1'b0;
         full_ff  <= 1'b0;
      end else begin
         row_ff   <= row_in;
         count_ff <= count_in;
         w_hit_ff <= w_hit_in;
         h_hit_ff <= h_hit_in;
         full_ff  <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      key_ff    <= key_in;
      w_slot_ff <= w_slot_in;
      h_slot_ff <= h_slot_in;
      scan_ff   <= scan_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      sts.action      = req_ff.action;
      sts.w_hit       = w_hit_ff;
      sts.h_hit       = h_hit_ff;
      sts.count_full  = count_full;
      sts.scan_stable = scan_next == scan_ff;
   end

   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PROCS))
      else $error("slot count beyond table size");

   a_hit_allocated: assert property (@(posedge clock) disable iff (reset)
      w_hit_ff |-> (CNT_W'(w_slot_ff) < count_ff))
      else $error("waiting slot not allocated");

endmodule

`default_nettype wire

// ===== sv/wfgd_ctrl.sv =====
// ----------------------------------------------------------------------------
// wfgd_ctrl
// Controller: sequences lookup, allocation, matrix update and scan.
// ----------------------------------------------------------------------------
`default_nettype none

module wfgd_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   input  wire wfgd_pkg::dp_sts_type sts,
   output wfgd_pkg::dp_cmd_type   cmd
);
   import wfgd_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = state_ff == ST_IDLE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_LOOK_W;
            end
         end
         ST_LOOK_W: begin
            cmd.look_w = 1'b1;
            state_in   = ST_RES_W;
         end
         ST_RES_W: begin
            state_in = ST_DONE;
            case (sts.action)
               ACT_ADD_WAIT: begin
                  if (sts.w_hit) begin
                     state_in = ST_LOOK_H;
                  end else if (sts.count_full) begin
                     cmd.set_full = 1'b1;
                  end else begin
                     cmd.alloc_w = 1'b1;
                     state_in    = ST_LOOK_H;
                  end
               end
               ACT_REMOVE_WAIT: state_in = ST_LOOK_H;
               ACT_CLEAR_WAITS: cmd.clr_row = sts.w_hit;
               ACT_REMOVE_PROC: begin
                  cmd.clr_row = sts.w_hit;
                  cmd.clr_col = sts.w_hit;
               end
               ACT_CLEAR_ALL: cmd.clr_all = 1'b1;
               ACT_DETECT: begin
                  cmd.scan_init = 1'b1;
                  state_in      = ST_SCAN;
               end
               ACT_QUERY: begin
                  if (sts.w_hit) begin
                     cmd.scan_init = 1'b1;
                     state_in      = ST_SCAN;
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_LOOK_H: begin
            cmd.look_h = 1'b1;
            state_in   = ST_RES_H;
         end
         ST_RES_H: begin
            state_in = ST_DONE;
            if (sts.action == ACT_ADD_WAIT) begin
               if (sts.h_hit) begin
                  cmd.set_edge = 1'b1;
               end else if (sts.count_full) begin
                  cmd.set_full = 1'b1;
               end else begin
                  cmd.alloc_h = 1'b1;
                  state_in    = ST_RES_H;
               end
            end else begin
               cmd.clr_edge = sts.w_hit && sts.h_hit;
            end
         end
         ST_SCAN: begin
            if (sts.scan_stable) begin
               state_in = ST_DONE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   a_no_alloc_when_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.alloc_w || cmd.alloc_h) |-> !sts.count_full)
      else $error("slot allocated with table full");

   a_one_table_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.look_w, cmd.look_h, cmd.alloc_w, cmd.alloc_h, cmd.clr_all}))
      else $error("conflicting key table commands");

   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> (rsp_valid && state_ff == ST_IDLE))
      else $error("result not presented after load");

endmodule

`default_nettype wire

// ===== sv/wait_for_graph_deadlock_detector_core.sv =====
// ----------------------------------------------------------------------------
// wait_for_graph_deadlock_detector_core
// Wait-for graph over process keys with cycle detection and per-key query.
// ----------------------------------------------------------------------------
// usage
//   req channel: one action with waiting and holding keys per transaction
//   rsp channel: one result per action (deadlock, table_full, slots_used)
//   one action is worked on at a time; req_ready is high only when idle
//   steps: IDLE takes the req; LOOK_W compares the waiting key with all used
//     slots in parallel, RES_W decides; clear waits, remove process, clear all,
//     unused codes, a query on an unknown key and add wait with no slot for the
//     waiting key then go to DONE; add wait / remove wait look up the holding
//     key in LOOK_H and RES_H, RES_H running again when the holding key takes
//     a new slot; detect and query go to SCAN, one reachability pass over the
//     matrix per cycle until stable; DONE then loads the result
//   the next req transaction is taken in the cycle after the result is loaded
//   the result sits in an output register, so the next action is taken
//   while a result waits; a stalled rsp holds only the following result
//   reset empties the slot table and wait matrix, leaving no wait-for cycle
// ----------------------------------------------------------------------------
`default_nettype none

module wait_for_graph_deadlock_detector_core #(
   parameter int MAX_PROCS = wfgd_pkg::MAX_PROCS_DEF,
   parameter int KEY_BITS  = wfgd_pkg::KEY_BITS_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire wfgd_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output wfgd_pkg::rsp_type   rsp_payload
);
   import wfgd_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   wfgd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   wfgd_dp #(
      .MAX_PROCS (MAX_PROCS),
      .KEY_BITS  (KEY_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== tb/wfgd_graph_check.sv =====
// ----------------------------------------------------------------------------
// wfgd_graph_check
// Watches the req and rsp channels of the deadlock detector, keeps its own
// copy of the slot table and wait-for matrix, predicts the result of every
// accepted req transaction and compares each rsp transaction field by field.
// ----------------------------------------------------------------------------
module wfgd_graph_check
   import wfgd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   output int      errors,
   output int      results_due,
   output int      deadlocks_seen,
   output int      fulls_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SLOTS = MAX_PROCS_DEF;

   logic [KEY_W-1:0]     slot_keys [MAX_SLOTS];
   logic [MAX_SLOTS-1:0] waits_for [MAX_SLOTS];
   int                   slots_in_use;
   rsp_type              expected_results [$];

   function automatic int lookup_slot(logic [KEY_W-1:0] key);
      for (int i = 0; i < slots_in_use; i++) begin
         if (slot_keys[i] == key) return i;
      end
      return -1;
   endfunction

   function automatic int claim_slot(logic [KEY_W-1:0] key);
      int s;
      s = lookup_slot(key);
      if (s >= 0) return s;
      if (slots_in_use >= MAX_SLOTS) return -1;
      slot_keys[slots_in_use] = key;
      waits_for[slots_in_use] = '0;
      slots_in_use++;
      return slots_in_use - 1;
   endfunction

   function automatic logic [MAX_SLOTS-1:0] reach_set(int s);
      logic [MAX_SLOTS-1:0] reach;
      logic [MAX_SLOTS-1:0] prev;
      reach = waits_for[s];
      do begin
         prev = reach;
         for (int j = 0; j < slots_in_use; j++) begin
            if (reach[j]) reach |= waits_for[j];
         end
      end while (reach != prev);
      return reach;
   endfunction

   function automatic rsp_type predict_result(req_type r);
      rsp_type              res;
      int                   w;
      int                   h;
      logic [MAX_SLOTS-1:0] reach;
      res = '0;
      case (r.action)
         ACT_ADD_WAIT: begin
            w = claim_slot(r.waiting_key);
            if (w < 0) begin
               res.table_full = 1'b1;
            end else begin
               h = claim_slot(r.holding_key);
               if (h < 0) res.table_full = 1'b1;
               else waits_for[w][h] = 1'b1;
            end
         end
         ACT_REMOVE_WAIT: begin
            w = lookup_slot(r.waiting_key);
            h = lookup_slot(r.holding_key);
            if (w >= 0 && h >= 0) waits_for[w][h] = 1'b0;
         end
         ACT_CLEAR_WAITS: begin
            w = lookup_slot(r.waiting_key);
            if (w >= 0) waits_for[w] = '0;
         end
         ACT_REMOVE_PROC: begin
            w = lookup_slot(r.waiting_key);
            if (w >= 0) begin
               waits_for[w] = '0;
               for (int i = 0; i < MAX_SLOTS; i++) waits_for[i][w] = 1'b0;
            end
         end
         ACT_CLEAR_ALL: begin
            for (int i = 0; i < MAX_SLOTS; i++) waits_for[i] = '0;
            slots_in_use = 0;
         end
         ACT_DETECT: begin
            for (int i = 0; i < slots_in_use; i++) begin
               reach = reach_set(i);
               if (reach[i]) res.deadlock = 1'b1;
            end
         end
         ACT_QUERY: begin
            w = lookup_slot(r.waiting_key);
            if (w >= 0) begin
               reach = reach_set(w);
               res.deadlock = reach[w];
            end
         end
         default: ;
      endcase
      res.slots_used = slots_in_use[SLOTS_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         slots_in_use = 0;
         for (int i = 0; i < MAX_SLOTS; i++) waits_for[i] = '0;
         expected_results.delete();
         errors         = 0;
         deadlocks_seen = 0;
         fulls_seen     = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: rsp transaction with nothing expected: %p", $time, rsp_payload);
               errors++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload.deadlock !== want.deadlock) begin
                  $display("%0t: deadlock expected %0b actual %0b", $time,
                           want.deadlock, rsp_payload.deadlock);
                  errors++;
               end
               if (rsp_payload.table_full !== want.table_full) begin
                  $display("%0t: table_full expected %0b actual %0b", $time,
                           want.table_full, rsp_payload.table_full);
                  errors++;
               end
               if (rsp_payload.slots_used !== want.slots_used) begin
                  $display("%0t: slots_used expected %0d actual %0d", $time,
                           want.slots_used, rsp_payload.slots_used);
                  errors++;
               end
               if (want.deadlock) deadlocks_seen++;
               if (want.table_full) fulls_seen++;
            end
         end
         if (req_valid && req_ready) expected_results.push_back(predict_result(req_payload));
      end
      results_due = expected_results.size();
   end

endmodule

// ===== tb/wait_for_graph_deadlock_detector_core_tb.sv =====
// ----------------------------------------------------------------------------
// wait_for_graph_deadlock_detector_core_tb
// Drives the deadlock detector with directed actions covering empty-table,
// unknown-key, self-wait and table-full cases, then with random actions over
// a small key pool plus cycle-building sequences, under random stalls on
// both channels, a long rsp hold-off and a full sender drain.
// ----------------------------------------------------------------------------
module wait_for_graph_deadlock_detector_core_tb;
   import wfgd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
   localparam int ITEM_TARGET = 1450;
   localparam int QUIET_LIMIT = 1000;
   localparam int LONG_HOLD   = 120;
   localparam int POOL_SIZE   = 20;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   int errors;
   int results_due;
   int deadlocks_seen;
   int fulls_seen;
   int items_sent;
   int quiet_cycles;
   bit send_gaps;
   bit recv_gaps;
   bit hold_rsp;

   logic [KEY_W-1:0] key_pool [POOL_SIZE];

   always #4 clock = ~clock;

   wait_for_graph_deadlock_detector_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   wfgd_graph_check graph_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .errors         (errors),
      .results_due    (results_due),
      .deadlocks_seen (deadlocks_seen),
      .fulls_seen     (fulls_seen)
   );

   // receiver side
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic send_action(logic [ACTION_W-1:0] act, logic [KEY_W-1:0] wkey,
                              logic [KEY_W-1:0] hkey);
      req_type r;
      r.action      = act;
      r.waiting_key = wkey;
      r.holding_key = hkey;
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
   endtask

   task automatic refresh_pool();
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom_range(0, 65535));
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      return KEY_W'($urandom_range(0, 65535));
   endfunction

   task automatic random_action();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 38)      send_action(ACT_ADD_WAIT, pick_key(), pick_key());
      else if (sel < 48) send_action(ACT_REMOVE_WAIT, pick_key(), pick_key());
      else if (sel < 55) send_action(ACT_CLEAR_WAITS, pick_key(), pick_key());
      else if (sel < 61) send_action(ACT_REMOVE_PROC, pick_key(), pick_key());
      else if (sel < 64) begin
         send_action(ACT_CLEAR_ALL, pick_key(), pick_key());
         refresh_pool();
      end
      else if (sel < 78) send_action(ACT_DETECT, pick_key(), pick_key());
      else if (sel < 95) send_action(ACT_QUERY, pick_key(), pick_key());
      else               send_action(ACT_UNUSED, pick_key(), pick_key());
   endtask

   // closes a ring of waits over one to four keys, mostly from the pool, then asks about it
   task automatic cycle_sequence();
      logic [KEY_W-1:0] ring [4];
      int n;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) ring[i] = pick_key();
      for (int i = 0; i < n; i++) send_action(ACT_ADD_WAIT, ring[i], ring[(i + 1) % n]);
      send_action(ACT_QUERY, ring[$urandom_range(0, n - 1)], pick_key());
      send_action(ACT_DETECT, pick_key(), pick_key());
      if ($urandom_range(0, 1)) send_action(ACT_REMOVE_WAIT, ring[0], ring[1 % n]);
   endtask

   initial begin
      bit held_once;
      bit drained_once;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      send_gaps   = 1'b1;
      recv_gaps   = 1'b1;
      hold_rsp    = 1'b0;
      items_sent  = 0;
      held_once   = 1'b0;
      drained_once = 1'b0;
      refresh_pool();
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // empty table and unknown keys
      send_action(ACT_DETECT, 16'h0000, 16'h0000);
      send_action(ACT_QUERY, 16'h1234, 16'h0000);
      send_action(ACT_REMOVE_WAIT, 16'h0001, 16'h0002);
      send_action(ACT_CLEAR_WAITS, 16'h0001, 16'hFFFF);
      send_action(ACT_REMOVE_PROC, 16'hFFFF, 16'h0000);
      // two-process cycle on extreme keys
      send_action(ACT_ADD_WAIT, 16'h0000, 16'hFFFF);
      send_action(ACT_ADD_WAIT, 16'hFFFF, 16'h0000);
      send_action(ACT_DETECT, 16'h0000, 16'h0000);
      send_action(ACT_QUERY, 16'hFFFF, 16'h0000);
      send_action(ACT_REMOVE_WAIT, 16'hFFFF, 16'h0000);
      send_action(ACT_DETECT, 16'hFFFF, 16'hFFFF);
      // self-wait, then remove process keeps its slot
      send_action(ACT_ADD_WAIT, 16'h0005, 16'h0005);
      send_action(ACT_QUERY, 16'h0005, 16'h0000);
      send_action(ACT_REMOVE_PROC, 16'h0005, 16'h0000);
      send_action(ACT_QUERY, 16'h0005, 16'h0000);
      send_action(ACT_CLEAR_WAITS, 16'h0000, 16'h0000);
      send_action(ACT_UNUSED, 16'hFFFF, 16'hFFFF);
      send_action(ACT_CLEAR_ALL, 16'h0000, 16'h0000);
      // fill the table up to and past its end
      for (int k = 0; k < 7; k++) send_action(ACT_ADD_WAIT, 16'h0100 + k, 16'h0200 + k);
      send_action(ACT_ADD_WAIT, 16'h0300, 16'h0300);
      send_action(ACT_ADD_WAIT, 16'h0400, 16'h0500);
      send_action(ACT_ADD_WAIT, 16'h0100, 16'h0600);
      send_action(ACT_ADD_WAIT, 16'h0600, 16'h0100);
      send_action(ACT_DETECT, 16'h0000, 16'h0000);
      send_action(ACT_CLEAR_ALL, 16'h0000, 16'h0000);

      while (items_sent < ITEM_TARGET) begin
         if (!held_once && items_sent >= 400) begin
            held_once = 1'b1;
            hold_rsp  = 1'b1;
         end
         if (!drained_once && items_sent >= 800) begin
            drained_once = 1'b1;
            drain_results();
         end
         if (items_sent >= ITEM_TARGET - 200) begin
            send_gaps = 1'b0;
            recv_gaps = 1'b0;
         end
         if ($urandom_range(0, 9) == 0) cycle_sequence();
         else random_action();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (40) @(negedge clock);

      $display("Ran %0d actions over all eight action codes: %0d deadlock reports, %0d table-full",
               items_sent, deadlocks_seen, fulls_seen);
      $display("Included a %0d-cycle rsp hold-off and a full drain of the req side", LONG_HOLD);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/wfgd_pkg.sv
sv/wfgd_dp.sv
sv/wfgd_ctrl.sv
sv/wait_for_graph_deadlock_detector_core.sv
tb/wfgd_graph_check.sv
tb/wait_for_graph_deadlock_detector_core_tb.sv
